// ----- rtl/dmag_pkg.sv -----
// Shared types and constants for the modulo address generator.
// No dependencies; used by dmag_update, dmag_regs and the top level.
package dmag_pkg;

    localparam int ADDR_W    = 16;
    localparam int CMD_W     = 3;
    localparam int IDX_W     = 2;
    // low bits of the 32-bit model arithmetic that can reach the result or a wrap test
    localparam int CALC_W    = ADDR_W + 1;
    localparam logic [ADDR_W-1:0] STEP_MIN = 16'h8000;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_ADDR = 3'd0,
        CMD_LOAD_WRAP = 3'd1,
        CMD_INC       = 3'd2,
        CMD_DEC       = 3'd3,
        CMD_ADD_STEP  = 3'd4,
        CMD_SUB_STEP  = 3'd5
    } cmd_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [IDX_W-1:0]   idx;
        logic [ADDR_W-1:0]  operand;
    } item_t;

    // write-back controls from the update logic to the register file
    typedef struct packed {
        logic               addr_we;
        logic [ADDR_W-1:0]  addr_data;
        logic               wrap_we;
        logic [ADDR_W-1:0]  wrap_data;
    } wb_t;

endpackage

// ----- rtl/dsp_modulo_address_generator.sv -----
// Top level of the modulo address generator: input register, update, result register.
// Depends on dmag_pkg, dmag_regs and dmag_update.
//
//  channel  | direction | tdata              | tuser
//  ---------+-----------+--------------------+----------------------------------
//  s_axis   | in        | operand[15:0]      | cmd[2:0], reg_index[4:3]
//  m_axis   | out       | address[15:0]      | -
//
// One transaction per cycle sustained while m_axis is not stalled; a command passes the
// input register, then the result register. The register file is read and written while
// the command is in the input register, so a command sees every earlier command's write-back.
// Reset clears address registers to 0 and wrap registers to 0xFFFF.
// A stall on m_axis holds the result register; s_axis keeps taking transactions
// while the input register is empty or moving.
module dsp_modulo_address_generator
#(
    parameter int NUM_ADDR_REGS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // operand[15:0]
    input  logic [4:0]  s_axis_tuser,   // cmd[2:0], reg_index[4:3]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // address[15:0]
);

    logic                          in_valid_reg;
    logic                          in_valid_next;
    dmag_pkg::item_t               in_item_reg;
    dmag_pkg::item_t               in_item_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [dmag_pkg::ADDR_W-1:0]   out_addr_reg;
    logic [dmag_pkg::ADDR_W-1:0]   out_addr_next;
    logic                          out_free;
    logic                          advance;
    logic                          hit;
    logic [dmag_pkg::ADDR_W-1:0]   ar;
    logic [dmag_pkg::ADDR_W-1:0]   wr;
    dmag_pkg::wb_t                 wb;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_addr_reg;

    dmag_regs #(
        .NUM_ADDR_REGS (NUM_ADDR_REGS)
    ) u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .idx   (in_item_reg.idx),
        .wr_en (advance),
        .wb    (wb),
        .hit   (hit),
        .ar    (ar),
        .wr    (wr)
    );

    dmag_update u_update (
        .item (in_item_reg),
        .ar   (ar),
        .wr   (wr),
        .wb   (wb)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_next        = 1'b1;
            in_item_next.cmd     = dmag_pkg::cmd_t'(s_axis_tuser[2:0]);
            in_item_next.idx     = s_axis_tuser[4:3];
            in_item_next.operand = s_axis_tdata;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_addr_next  = out_addr_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            // out-of-range index reads as zero and writes nothing
            out_addr_next  = (hit && wb.addr_we) ? wb.addr_data : ar;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg  <= in_item_next;
        out_addr_reg <= out_addr_next;
    end

`ifndef SYNTHESIS
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty result register");

    a_load_addr_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && hit && (in_item_reg.cmd == dmag_pkg::CMD_LOAD_ADDR))
        |=> (m_axis_tdata == $past(in_item_reg.operand)))
        else $error("load address did not return the loaded value");

    a_result_from_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result appeared without a pending transaction");
`endif

endmodule

// ----- rtl/dmag_update.sv -----
// Combinational address update: load address, load wrap, +1, -1, +step, -step with modulo wrap.
// Depends on dmag_pkg.
module dmag_update
(
    input  dmag_pkg::item_t                  item,
    input  logic [dmag_pkg::ADDR_W-1:0]      ar,
    input  logic [dmag_pkg::ADDR_W-1:0]      wr,
    output dmag_pkg::wb_t                    wb
);

    localparam int W = dmag_pkg::CALC_W;

    logic [W-1:0] ar_x;
    logic [W-1:0] wr_x;
    logic [W-1:0] wp1;
    logic [W-1:0] mx;
    logic [W-1:0] s_x;
    logic [W-1:0] n_inc;
    logic [W-1:0] n_dec;
    logic [W-1:0] n_add;
    logic [W-1:0] n_sub;
    logic [W-1:0] d_add;
    logic [W-1:0] d_sub;
    logic [W-1:0] n_res;
    logic         step_neg;

    always_comb
    begin
        ar_x     = {1'b0, ar};
        wr_x     = {1'b0, wr};
        wp1      = wr_x + W'(1);
        mx       = {wr | dmag_pkg::ADDR_W'(1), 1'b0};
        s_x      = {item.operand[dmag_pkg::ADDR_W-1], item.operand};
        step_neg = item.operand[dmag_pkg::ADDR_W-1];

        n_inc = ar_x + W'(1);
        if ((n_inc ^ ar_x) > mx)
        begin
            n_inc = n_inc - wp1;
        end

        n_dec = ar_x + wr_x;
        if (((n_dec ^ ar_x) & mx) > wr_x)
        begin
            n_dec = n_dec - wp1;
        end

        n_add = ar_x + s_x;
        d_add = (n_add ^ ar_x ^ s_x) & mx;
        if (!step_neg)
        begin
            if (d_add > wr_x)
            begin
                n_add = n_add - wp1;
            end
        end
        else if ((((n_add + wp1) ^ n_add) & d_add) <= wr_x)
        begin
            n_add = n_add + wp1;
        end

        // most negative step takes the underflow path, like a positive one
        n_sub = ar_x - s_x;
        d_sub = (n_sub ^ ar_x ^ ~s_x) & mx;
        if (step_neg && (item.operand != dmag_pkg::STEP_MIN))
        begin
            if (d_sub > wr_x)
            begin
                n_sub = n_sub - wp1;
            end
        end
        else if ((((n_sub + wp1) ^ n_sub) & d_sub) <= wr_x)
        begin
            n_sub = n_sub + wp1;
        end

        wb.wrap_we   = 1'b0;
        wb.wrap_data = item.operand;
        wb.addr_we   = 1'b1;
        n_res        = ar_x;
        case (item.cmd)
            dmag_pkg::CMD_LOAD_ADDR: n_res = {1'b0, item.operand};
            dmag_pkg::CMD_LOAD_WRAP: wb.wrap_we = 1'b1;
            dmag_pkg::CMD_INC:       n_res = n_inc;
            dmag_pkg::CMD_DEC:       n_res = n_dec;
            dmag_pkg::CMD_ADD_STEP:  n_res = n_add;
            dmag_pkg::CMD_SUB_STEP:  n_res = n_sub;
            default:                 wb.addr_we = 1'b0;
        endcase
        wb.addr_data = n_res[dmag_pkg::ADDR_W-1:0];
    end

endmodule

// ----- rtl/dmag_regs.sv -----
// Address and wrap register file, one read port and one write port.
// Depends on dmag_pkg.
module dmag_regs
#(
    parameter int NUM_ADDR_REGS = 4
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [dmag_pkg::IDX_W-1:0]       idx,
    input  logic                             wr_en,
    input  dmag_pkg::wb_t                    wb,
    output logic                             hit,
    output logic [dmag_pkg::ADDR_W-1:0]      ar,
    output logic [dmag_pkg::ADDR_W-1:0]      wr
);

    logic [dmag_pkg::ADDR_W-1:0] addr_reg  [NUM_ADDR_REGS];
    logic [dmag_pkg::ADDR_W-1:0] addr_next [NUM_ADDR_REGS];
    logic [dmag_pkg::ADDR_W-1:0] wrap_reg  [NUM_ADDR_REGS];
    logic [dmag_pkg::ADDR_W-1:0] wrap_next [NUM_ADDR_REGS];

    always_comb
    begin
        hit = 1'b0;
        ar  = '0;
        wr  = '0;
        for (int i = 0; i < NUM_ADDR_REGS; i++)
        begin
            addr_next[i] = addr_reg[i];
            wrap_next[i] = wrap_reg[i];
            if (32'(idx) == i)
            begin
                hit = 1'b1;
                ar  = addr_reg[i];
                wr  = wrap_reg[i];
                if (wr_en && wb.addr_we)
                begin
                    addr_next[i] = wb.addr_data;
                end
                if (wr_en && wb.wrap_we)
                begin
                    wrap_next[i] = wb.wrap_data;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ADDR_REGS; i++)
            begin
                addr_reg[i] <= '0;
                wrap_reg[i] <= '1;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_ADDR_REGS; i++)
            begin
                addr_reg[i] <= addr_next[i];
                wrap_reg[i] <= wrap_next[i];
            end
        end
    end

endmodule
